@@ design/dces_pkg.sv @@
// ----------------------------------------------------------------------------
// dces_pkg
// Shared types and constants of the delta coordinate edit stream decoder:
// parser phases, the edit command passed from parser to executor, defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package dces_pkg;

    localparam int unsigned COORD_WIDTH_DEF = 32;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] ESCAPE_BYTE  = 8'h80;
    localparam logic [7:0] VARINT_MASK  = 8'h7f;
    localparam int unsigned VARINT_STEP = 7;
    localparam int unsigned VARINT_LIMIT = 32;

    typedef enum logic [3:0] {
        PH_DX     = 4'd0,
        PH_VX     = 4'd1,
        PH_VY     = 4'd2,
        PH_VZ     = 4'd3,
        PH_DX_ESC = 4'd4,
        PH_DY     = 4'd5,
        PH_DZ     = 4'd6,
        PH_HEALTH = 4'd7,
        PH_C0     = 4'd8,
        PH_C1     = 4'd9,
        PH_C2     = 4'd10
    } phase_t;

    typedef struct packed {
        logic        trunc;
        logic [31:0] cur_x;
        logic [31:0] cur_y;
        logic [31:0] cur_z;
        logic [7:0]  dx;
        logic [7:0]  dy;
        logic [7:0]  dz;
        logic        has_color;
        logic [31:0] color;
    } edit_cmd_t;

endpackage

`default_nettype wire

@@ design/delta_coordinate_edit_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// delta_coordinate_edit_stream_decoder
// Accepts one payload byte per cycle; the parser pushes an edit command to a
// short queue and the executor turns it into an absolute edit.
// A finished edit passes through the queue and then the output register.
// Throughput: one byte per cycle while m_ready stays high.
// Reset: parser phase, cursor, varint state, queue and output valid clear.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_coordinate_edit_stream_decoder #(
    parameter int unsigned COORD_WIDTH = dces_pkg::COORD_WIDTH_DEF,
    parameter int unsigned QUEUE_DEPTH = dces_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_data_byte,
    input  wire logic          s_packet_start,
    input  wire logic          s_packet_last,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic signed [31:0] m_edit_x,
    output logic signed [31:0] m_edit_y,
    output logic signed [31:0] m_edit_z,
    output logic               m_has_color,
    output logic [31:0]        m_color_word,
    output logic               m_status
);
    import dces_pkg::*;

    edit_cmd_t push_cmd, pop_cmd;
    logic      push_valid, push_ready, pop_valid, pop_ready;

    dces_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_packet_start (s_packet_start),
        .s_packet_last  (s_packet_last),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_cmd       (push_cmd)
    );

    dces_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    dces_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_cmd      (pop_cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_edit_x     (m_edit_x),
        .m_edit_y     (m_edit_y),
        .m_edit_z     (m_edit_z),
        .m_has_color  (m_has_color),
        .m_color_word (m_color_word),
        .m_status     (m_status)
    );

endmodule

`default_nettype wire

@@ design/dces_front.sv @@
// ----------------------------------------------------------------------------
// dces_front
// Byte parser: tracks the edit phase, collects varints into the cursor and
// the deltas and colour, and pushes one edit command per finished edit or
// truncated packet.
// ----------------------------------------------------------------------------
`default_nettype none

module dces_front #(
    parameter int unsigned COORD_WIDTH = dces_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [7:0]          s_data_byte,
    input  wire logic                s_packet_start,
    input  wire logic                s_packet_last,
    output logic                     push_valid,
    input  wire logic                push_ready,
    output dces_pkg::edit_cmd_t      push_cmd
);
    import dces_pkg::*;

    phase_t                 phase_reg, phase_next, phase_eff, parse_next;
    logic [COORD_WIDTH-1:0] cur_x_reg, cur_y_reg, cur_z_reg;
    logic [COORD_WIDTH-1:0] cur_x_next, cur_y_next, cur_z_next;
    logic [COORD_WIDTH-1:0] cur_x_eff, cur_y_eff, cur_z_eff, vcoord;
    logic [31:0]            acc_reg, acc_next, acc_eff, acc_upd, grp;
    logic [5:0]             shift_reg, shift_next, shift_eff, shift_upd;
    logic [7:0]             dx_reg, dy_reg, dz_reg, dx_next, dy_next, dz_next;
    logic [31:0]            color_reg, color_next;
    logic                   take, more, in_varint, emit_edit, trunc;

    assign s_ready   = push_ready;
    assign take      = s_valid && s_ready;
    assign phase_eff = s_packet_start ? PH_DX : phase_reg;
    assign cur_x_eff = s_packet_start ? '0 : cur_x_reg;
    assign cur_y_eff = s_packet_start ? '0 : cur_y_reg;
    assign cur_z_eff = s_packet_start ? '0 : cur_z_reg;
    assign acc_eff   = s_packet_start ? '0 : acc_reg;
    assign shift_eff = s_packet_start ? '0 : shift_reg;

    assign more      = s_data_byte[7];
    assign grp       = 32'(s_data_byte & VARINT_MASK) << shift_eff[4:0];
    assign acc_upd   = (shift_eff < 6'(VARINT_LIMIT)) ? (acc_eff | grp) : acc_eff;
    assign shift_upd = (more && shift_eff < 6'(VARINT_LIMIT)) ?
                       shift_eff + 6'(VARINT_STEP) : shift_eff;
    assign vcoord    = acc_upd[COORD_WIDTH-1:0];
    assign in_varint = (phase_eff == PH_VX) || (phase_eff == PH_VY) ||
                       (phase_eff == PH_VZ);

    always_comb begin
        unique case (phase_eff)
            PH_VX:     parse_next = more ? PH_VX : PH_VY;
            PH_VY:     parse_next = more ? PH_VY : PH_VZ;
            PH_VZ:     parse_next = more ? PH_VZ : PH_DX_ESC;
            PH_DX_ESC: parse_next = PH_DY;
            PH_DY:     parse_next = PH_DZ;
            PH_DZ:     parse_next = PH_HEALTH;
            PH_HEALTH: parse_next = (s_data_byte == 8'h00) ? PH_DX : PH_C0;
            PH_C0:     parse_next = PH_C1;
            PH_C1:     parse_next = PH_C2;
            PH_C2:     parse_next = PH_DX;
            default:   parse_next = (s_data_byte == ESCAPE_BYTE) ? PH_VX : PH_DY;
        endcase
        phase_next = trunc ? PH_DX : parse_next;
    end

    always_comb begin
        emit_edit  = ((phase_eff == PH_HEALTH) && (s_data_byte == 8'h00)) ||
                     (phase_eff == PH_C2);
        trunc      = s_packet_last && !emit_edit && (parse_next != PH_DX);
        cur_x_next = cur_x_eff;
        cur_y_next = cur_y_eff;
        cur_z_next = cur_z_eff;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        dz_next    = dz_reg;
        color_next = color_reg;
        acc_next   = (in_varint && more && !trunc) ? acc_upd : '0;
        shift_next = (in_varint && more && !trunc) ? shift_upd : '0;
        unique case (phase_eff)
            PH_VX:     if (!more) cur_x_next = vcoord;
            PH_VY:     if (!more) cur_y_next = vcoord;
            PH_VZ:     if (!more) cur_z_next = vcoord;
            PH_DX_ESC: dx_next = s_data_byte;
            PH_DY:     dy_next = s_data_byte;
            PH_DZ:     dz_next = s_data_byte;
            PH_HEALTH: color_next = {s_data_byte, 24'h0};
            PH_C0:     color_next = {color_reg[31:8], s_data_byte};
            PH_C1:     color_next = {color_reg[31:16], s_data_byte, color_reg[7:0]};
            PH_C2:     color_next = {color_reg[31:24], s_data_byte, color_reg[15:0]};
            default:   if (s_data_byte != ESCAPE_BYTE) dx_next = s_data_byte;
        endcase

        push_valid         = take && (emit_edit || trunc);
        push_cmd.trunc     = trunc;
        push_cmd.cur_x     = 32'($signed(cur_x_eff));
        push_cmd.cur_y     = 32'($signed(cur_y_eff));
        push_cmd.cur_z     = 32'($signed(cur_z_eff));
        push_cmd.dx        = dx_reg;
        push_cmd.dy        = dy_reg;
        push_cmd.dz        = dz_reg;
        push_cmd.has_color = (phase_eff == PH_C2);
        push_cmd.color     = (phase_eff == PH_C2) ? color_next : 32'h0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DX;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            cur_z_reg <= '0;
            acc_reg   <= '0;
            shift_reg <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            cur_z_reg <= cur_z_next;
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            dz_reg    <= dz_next;
            color_reg <= color_next;
        end
    end

endmodule

`default_nettype wire

@@ design/dces_queue.sv @@
// ----------------------------------------------------------------------------
// dces_queue
// Short FIFO of edit commands between the parser and the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module dces_queue #(
    parameter int unsigned DEPTH = dces_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push_valid,
    output logic                     push_ready,
    input  wire dces_pkg::edit_cmd_t push_cmd,
    output logic                     pop_valid,
    input  wire logic                pop_ready,
    output dces_pkg::edit_cmd_t      pop_cmd
);
    import dces_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    edit_cmd_t       entry_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ design/dces_back.sv @@
// ----------------------------------------------------------------------------
// dces_back
// Executor: adds the deltas to the cursor with coordinate wrap (a truncated
// packet gives zeros) and holds the edit in the output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dces_back #(
    parameter int unsigned COORD_WIDTH = dces_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                pop_valid,
    output logic                     pop_ready,
    input  wire dces_pkg::edit_cmd_t pop_cmd,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [31:0]       m_edit_x,
    output logic signed [31:0]       m_edit_y,
    output logic signed [31:0]       m_edit_z,
    output logic                     m_has_color,
    output logic [31:0]              m_color_word,
    output logic                     m_status
);
    import dces_pkg::*;

    logic               valid_reg;
    logic signed [31:0] x_reg, y_reg, z_reg, x_next, y_next, z_next;
    logic [31:0]        sum_x, sum_y, sum_z, color_reg, color_next;
    logic               has_color_reg, has_color_next, status_reg;
    logic               load;

    assign pop_ready = !valid_reg || m_ready;
    assign load      = pop_valid && pop_ready;

    always_comb begin
        sum_x = pop_cmd.cur_x + 32'($signed(pop_cmd.dx));
        sum_y = pop_cmd.cur_y + 32'($signed(pop_cmd.dy));
        sum_z = pop_cmd.cur_z + 32'($signed(pop_cmd.dz));
        if (pop_cmd.trunc) begin
            x_next         = '0;
            y_next         = '0;
            z_next         = '0;
            has_color_next = 1'b0;
            color_next     = '0;
        end else begin
            x_next         = 32'($signed(sum_x[COORD_WIDTH-1:0]));
            y_next         = 32'($signed(sum_y[COORD_WIDTH-1:0]));
            z_next         = 32'($signed(sum_z[COORD_WIDTH-1:0]));
            has_color_next = pop_cmd.has_color;
            color_next     = pop_cmd.color;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop_ready) begin
            valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg         <= x_next;
            y_reg         <= y_next;
            z_reg         <= z_next;
            has_color_reg <= has_color_next;
            color_reg     <= color_next;
            status_reg    <= pop_cmd.trunc;
        end
    end

    assign m_valid      = valid_reg;
    assign m_edit_x     = x_reg;
    assign m_edit_y     = y_reg;
    assign m_edit_z     = z_reg;
    assign m_has_color  = has_color_reg;
    assign m_color_word = color_reg;
    assign m_status     = status_reg;

endmodule

`default_nettype wire
